// File: sv/pmau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmau_pkg: shared types and constants of the prime modular arithmetic unit
// Widths, the modulus, the Barrett constant and controller/datapath structs.
// ----------------------------------------------------------------------------
package pmau_pkg;

    localparam int RES_W    = 30;
    localparam int RAW_W    = 64;
    localparam int EXP_W    = 63;
    localparam int ACT_W    = 3;
    localparam int CHUNK_W  = 16;
    localparam int N_CHUNKS = RAW_W / CHUNK_W;
    localparam int CNT_W    = $clog2(EXP_W);
    localparam int PROD_W   = 2 * RES_W;
    localparam int QF_W     = 2 * RES_W + 2;
    localparam int RED_W    = RES_W + 2;
    localparam int MMV_W    = 4;

    localparam logic [RES_W-1:0] MODULUS    = 30'd1000000007;
    localparam logic [EXP_W-1:0] FERMAT_EXP = 63'd1000000005;
    localparam logic [RES_W-1:0] CHUNK_MUL  = RES_W'(64'd1 << CHUNK_W);

    // floor(2^60 / MODULUS), worked out at elaboration
    localparam logic [63:0]      MU_WIDE = 64'h1000_0000_0000_0000 / 64'd1000000007;
    localparam logic [RES_W:0]   MU      = MU_WIDE[RES_W:0];

    typedef enum logic [ACT_W-1:0] {
        ACT_REDUCE  = 3'd0,
        ACT_NEGATE  = 3'd1,
        ACT_ADD     = 3'd2,
        ACT_SUB     = 3'd3,
        ACT_MUL     = 3'd4,
        ACT_POW     = 3'd5,
        ACT_INVERSE = 3'd6,
        ACT_DIVIDE  = 3'd7
    } t_action;

    typedef enum logic [2:0] {
        MM_SQR      = 3'd0,
        MM_ACC_BASE = 3'd1,
        MM_A_B      = 3'd2,
        MM_A_ACC    = 3'd3,
        MM_CHUNK    = 3'd4
    } t_mm_sel;

    typedef enum logic [2:0] {
        RES_ACC = 3'd0,
        RES_RED = 3'd1,
        RES_NEG = 3'd2,
        RES_ADD = 3'd3,
        RES_SUB = 3'd4
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     ld_acc_one;
        logic     ld_fermat;
        logic     ld_base_b;
        logic     mm_start;
        t_mm_sel  mm_sel;
        logic     exp_shift;
        logic     chunk_shift;
        logic     out_load;
        t_res_sel res_sel;
    } t_cmd;

    typedef struct packed {
        logic mm_done;
        logic mm_busy;
        logic exp_bit;
        logic out_free;
    } t_sts;

endpackage

// File: sv/pmau_modmul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmau_modmul: four-stage multiply-add and Barrett reduction
// Computes (x * y + z) mod MODULUS through the registers r_p, r_qf, r_r and r_res.
// ----------------------------------------------------------------------------
module pmau_modmul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pmau_pkg::RES_W-1:0]   i_x,
    input  logic [pmau_pkg::RES_W-1:0]   i_y,
    input  logic [pmau_pkg::CHUNK_W-1:0] i_z,
    output logic                         o_done,
    output logic                         o_busy,
    output logic [pmau_pkg::RES_W-1:0]   o_res
);

    logic [pmau_pkg::MMV_W-1:0]  r_vld;
    logic [pmau_pkg::PROD_W-1:0] r_p;
    logic [pmau_pkg::RED_W-1:0]  r_p_lo;
    logic [pmau_pkg::QF_W-1:0]   r_qf;
    logic [pmau_pkg::RED_W-1:0]  r_r;
    logic [pmau_pkg::RES_W-1:0]  r_res;

    logic [pmau_pkg::PROD_W-1:0] n_p;
    logic [pmau_pkg::QF_W-1:0]   n_qf;
    logic [pmau_pkg::RES_W:0]    w_q;
    logic [pmau_pkg::QF_W-1:0]   w_qm;
    logic [pmau_pkg::RED_W-1:0]  n_r;
    logic [pmau_pkg::RED_W-1:0]  w_m;
    logic [pmau_pkg::RED_W-1:0]  w_r1;
    logic [pmau_pkg::RED_W-1:0]  w_r2;

    always_comb begin
        n_p  = pmau_pkg::PROD_W'(i_x) * pmau_pkg::PROD_W'(i_y)
             + pmau_pkg::PROD_W'(i_z);
        // estimate the quotient from the top bits of the product
        n_qf = pmau_pkg::QF_W'(r_p[pmau_pkg::PROD_W-1:pmau_pkg::RES_W-1])
             * pmau_pkg::QF_W'(pmau_pkg::MU);
        w_q  = r_qf[pmau_pkg::QF_W-1:pmau_pkg::RES_W+1];
        w_qm = pmau_pkg::QF_W'(w_q) * pmau_pkg::QF_W'(pmau_pkg::MODULUS);
        n_r  = r_p_lo - w_qm[pmau_pkg::RED_W-1:0];
        // the estimate is short by at most two
        w_m  = pmau_pkg::RED_W'(pmau_pkg::MODULUS);
        w_r1 = (r_r >= w_m) ? r_r - w_m : r_r;
        w_r2 = (w_r1 >= w_m) ? w_r1 - w_m : w_r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[pmau_pkg::MMV_W-2:0], i_start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_p_lo <= r_p[pmau_pkg::RED_W-1:0];
        r_qf   <= n_qf;
        r_r    <= n_r;
        r_res  <= w_r2[pmau_pkg::RES_W-1:0];
    end

    assign o_done = r_vld[pmau_pkg::MMV_W-1];
    assign o_busy = |r_vld;
    assign o_res  = r_res;

endmodule

// File: sv/pmau_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmau_datapath: operand registers, modular multiplier and result register
// Holds the reduced operands, accumulator, exponent and magnitude shifters.
// ----------------------------------------------------------------------------
module pmau_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pmau_pkg::t_cmd                i_cmd,
    output pmau_pkg::t_sts                o_sts,
    input  logic signed [pmau_pkg::RAW_W-1:0] i_raw_value,
    input  logic [pmau_pkg::RES_W-1:0]    i_operand_a,
    input  logic [pmau_pkg::RES_W-1:0]    i_operand_b,
    input  logic [pmau_pkg::EXP_W-1:0]    i_exponent,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [pmau_pkg::RES_W-1:0]    o_result_residue
);

    logic [pmau_pkg::RES_W-1:0] r_a;
    logic [pmau_pkg::RES_W-1:0] r_b;
    logic [pmau_pkg::RES_W-1:0] r_base;
    logic [pmau_pkg::RES_W-1:0] r_acc;
    logic [pmau_pkg::EXP_W-1:0] r_exp;
    logic [pmau_pkg::RAW_W-1:0] r_mag;
    logic                       r_neg;
    logic                       r_out_valid;
    logic [pmau_pkg::RES_W-1:0] r_out_res;

    logic [pmau_pkg::RES_W-1:0]   w_a_red;
    logic [pmau_pkg::RES_W-1:0]   w_b_red;
    logic [pmau_pkg::RAW_W-1:0]   w_mag;
    logic [pmau_pkg::RES_W-1:0]   w_x;
    logic [pmau_pkg::RES_W-1:0]   w_y;
    logic [pmau_pkg::CHUNK_W-1:0] w_z;
    logic                         w_mm_done;
    logic                         w_mm_busy;
    logic [pmau_pkg::RES_W-1:0]   w_mm_res;
    logic [pmau_pkg::RES_W:0]     w_sum;
    logic [pmau_pkg::RES_W:0]     w_dif;
    logic [pmau_pkg::RES_W-1:0]   n_out_res;

    function automatic logic [pmau_pkg::RES_W-1:0] mod_neg(
        input logic [pmau_pkg::RES_W-1:0] x
    );
        mod_neg = (x == '0) ? '0 : pmau_pkg::MODULUS - x;
    endfunction

    always_comb begin
        // operands are below 2^30, which is less than twice the modulus
        w_a_red = (i_operand_a >= pmau_pkg::MODULUS) ? i_operand_a - pmau_pkg::MODULUS
                                                     : i_operand_a;
        w_b_red = (i_operand_b >= pmau_pkg::MODULUS) ? i_operand_b - pmau_pkg::MODULUS
                                                     : i_operand_b;
        w_mag   = i_raw_value[pmau_pkg::RAW_W-1] ? (~i_raw_value) + 1'b1 : i_raw_value;
    end

    always_comb begin
        w_x = r_acc;
        w_y = r_acc;
        w_z = '0;
        case (i_cmd.mm_sel)
            pmau_pkg::MM_SQR: begin
                w_x = r_acc;
                w_y = r_acc;
            end
            pmau_pkg::MM_ACC_BASE: begin
                w_x = r_acc;
                w_y = r_base;
            end
            pmau_pkg::MM_A_B: begin
                w_x = r_a;
                w_y = r_b;
            end
            pmau_pkg::MM_A_ACC: begin
                w_x = r_a;
                w_y = r_acc;
            end
            pmau_pkg::MM_CHUNK: begin
                // shift the running residue by one chunk and add the next one
                w_x = r_acc;
                w_y = pmau_pkg::CHUNK_MUL;
                w_z = r_mag[pmau_pkg::RAW_W-1:pmau_pkg::RAW_W-pmau_pkg::CHUNK_W];
            end
            default: begin
                w_x = r_acc;
                w_y = r_acc;
            end
        endcase
    end

    pmau_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mm_start),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_z     (w_z),
        .o_done  (w_mm_done),
        .o_busy  (w_mm_busy),
        .o_res   (w_mm_res)
    );

    always_comb begin
        w_sum = {1'b0, r_a} + {1'b0, r_b};
        w_dif = {1'b0, r_a} + {1'b0, pmau_pkg::MODULUS - r_b};
        case (i_cmd.res_sel)
            pmau_pkg::RES_ACC: n_out_res = r_acc;
            pmau_pkg::RES_RED: n_out_res = r_neg ? mod_neg(r_acc) : r_acc;
            pmau_pkg::RES_NEG: n_out_res = mod_neg(r_a);
            pmau_pkg::RES_ADD: begin
                n_out_res = (w_sum >= {1'b0, pmau_pkg::MODULUS})
                          ? pmau_pkg::RES_W'(w_sum - {1'b0, pmau_pkg::MODULUS})
                          : w_sum[pmau_pkg::RES_W-1:0];
            end
            pmau_pkg::RES_SUB: begin
                n_out_res = (w_dif >= {1'b0, pmau_pkg::MODULUS})
                          ? pmau_pkg::RES_W'(w_dif - {1'b0, pmau_pkg::MODULUS})
                          : w_dif[pmau_pkg::RES_W-1:0];
            end
            default: n_out_res = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a    <= w_a_red;
            r_b    <= w_b_red;
            r_base <= i_cmd.ld_base_b ? w_b_red : w_a_red;
            r_acc  <= i_cmd.ld_acc_one ? pmau_pkg::RES_W'(1) : '0;
            r_exp  <= i_cmd.ld_fermat ? pmau_pkg::FERMAT_EXP : i_exponent;
            r_mag  <= w_mag;
            r_neg  <= i_raw_value[pmau_pkg::RAW_W-1];
        end else begin
            if (w_mm_done) begin
                r_acc <= w_mm_res;
            end
            if (i_cmd.exp_shift) begin
                r_exp <= {r_exp[pmau_pkg::EXP_W-2:0], 1'b0};
            end
            if (i_cmd.chunk_shift) begin
                r_mag <= {r_mag[pmau_pkg::RAW_W-pmau_pkg::CHUNK_W-1:0],
                          {pmau_pkg::CHUNK_W{1'b0}}};
            end
        end
        if (i_cmd.out_load) begin
            r_out_res <= n_out_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.mm_done  = w_mm_done;
    assign o_sts.mm_busy  = w_mm_busy;
    assign o_sts.exp_bit  = r_exp[pmau_pkg::EXP_W-1];
    assign o_sts.out_free = !r_out_valid || !i_stall;

    assign o_valid          = r_out_valid;
    assign o_result_residue = r_out_res;

endmodule

// File: sv/pmau_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmau_ctrl: sequencer of the prime modular arithmetic unit
// Walks reduce chunks and exponent bits and issues multiplier operations.
// ----------------------------------------------------------------------------
module pmau_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [pmau_pkg::ACT_W-1:0] i_action,
    output logic                       o_stall,
    output pmau_pkg::t_cmd             o_cmd,
    input  pmau_pkg::t_sts             i_sts
);

    typedef enum logic [9:0] {
        S_IDLE       = 10'b00_0000_0001,
        S_RED_ISSUE  = 10'b00_0000_0010,
        S_RED_WAIT   = 10'b00_0000_0100,
        S_SQR_ISSUE  = 10'b00_0000_1000,
        S_SQR_WAIT   = 10'b00_0001_0000,
        S_MULB_ISSUE = 10'b00_0010_0000,
        S_MULB_WAIT  = 10'b00_0100_0000,
        S_FIN_ISSUE  = 10'b00_1000_0000,
        S_FIN_WAIT   = 10'b01_0000_0000,
        S_OUT        = 10'b10_0000_0000
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    pmau_pkg::t_action          r_action;
    pmau_pkg::t_action          n_action;
    logic [pmau_pkg::CNT_W-1:0] r_cnt;
    logic [pmau_pkg::CNT_W-1:0] n_cnt;
    pmau_pkg::t_action          w_in_act;
    logic                       w_last_bit;

    assign w_in_act   = pmau_pkg::t_action'(i_action);
    assign w_last_bit = (r_cnt == pmau_pkg::CNT_W'(pmau_pkg::EXP_W - 1));

    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        n_cnt    = r_cnt;
        o_cmd    = '0;
        o_cmd.mm_sel  = pmau_pkg::MM_SQR;
        o_cmd.res_sel = pmau_pkg::RES_ACC;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.ld_acc_one = (w_in_act != pmau_pkg::ACT_REDUCE);
                    o_cmd.ld_fermat  = (w_in_act == pmau_pkg::ACT_INVERSE) ||
                                       (w_in_act == pmau_pkg::ACT_DIVIDE);
                    o_cmd.ld_base_b  = (w_in_act == pmau_pkg::ACT_DIVIDE);
                    n_action = w_in_act;
                    n_cnt    = '0;
                    case (w_in_act)
                        pmau_pkg::ACT_REDUCE:  n_state = S_RED_ISSUE;
                        pmau_pkg::ACT_MUL:     n_state = S_FIN_ISSUE;
                        pmau_pkg::ACT_POW,
                        pmau_pkg::ACT_INVERSE,
                        pmau_pkg::ACT_DIVIDE:  n_state = S_SQR_ISSUE;
                        default:               n_state = S_OUT;
                    endcase
                end
            end
            S_RED_ISSUE: begin
                o_cmd.mm_start = 1'b1;
                o_cmd.mm_sel   = pmau_pkg::MM_CHUNK;
                n_state        = S_RED_WAIT;
            end
            S_RED_WAIT: begin
                if (i_sts.mm_done) begin
                    o_cmd.chunk_shift = 1'b1;
                    if (r_cnt == pmau_pkg::CNT_W'(pmau_pkg::N_CHUNKS - 1)) begin
                        n_state = S_OUT;
                    end else begin
                        n_cnt   = r_cnt + 1'b1;
                        n_state = S_RED_ISSUE;
                    end
                end
            end
            S_SQR_ISSUE: begin
                o_cmd.mm_start = 1'b1;
                o_cmd.mm_sel   = pmau_pkg::MM_SQR;
                n_state        = S_SQR_WAIT;
            end
            S_SQR_WAIT, S_MULB_WAIT: begin
                if (i_sts.mm_done) begin
                    if (r_state == S_SQR_WAIT && i_sts.exp_bit) begin
                        n_state = S_MULB_ISSUE;
                    end else begin
                        // advance to the next exponent bit
                        o_cmd.exp_shift = 1'b1;
                        if (w_last_bit) begin
                            n_state = (r_action == pmau_pkg::ACT_DIVIDE) ? S_FIN_ISSUE
                                                                         : S_OUT;
                        end else begin
                            n_cnt   = r_cnt + 1'b1;
                            n_state = S_SQR_ISSUE;
                        end
                    end
                end
            end
            S_MULB_ISSUE: begin
                o_cmd.mm_start = 1'b1;
                o_cmd.mm_sel   = pmau_pkg::MM_ACC_BASE;
                n_state        = S_MULB_WAIT;
            end
            S_FIN_ISSUE: begin
                o_cmd.mm_start = 1'b1;
                o_cmd.mm_sel   = (r_action == pmau_pkg::ACT_DIVIDE) ? pmau_pkg::MM_A_ACC
                                                                    : pmau_pkg::MM_A_B;
                n_state        = S_FIN_WAIT;
            end
            S_FIN_WAIT: begin
                if (i_sts.mm_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                case (r_action)
                    pmau_pkg::ACT_REDUCE: o_cmd.res_sel = pmau_pkg::RES_RED;
                    pmau_pkg::ACT_NEGATE: o_cmd.res_sel = pmau_pkg::RES_NEG;
                    pmau_pkg::ACT_ADD:    o_cmd.res_sel = pmau_pkg::RES_ADD;
                    pmau_pkg::ACT_SUB:    o_cmd.res_sel = pmau_pkg::RES_SUB;
                    default:              o_cmd.res_sel = pmau_pkg::RES_ACC;
                endcase
                // hold until the output register can take the item
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_action <= pmau_pkg::ACT_REDUCE;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_action <= n_action;
            r_cnt    <= n_cnt;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

// File: sv/prime_modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prime_modular_arithmetic_unit: arithmetic modulo the prime 1000000007
// Reduce, negate, add, subtract, multiply, power, inverse and divide.
// ----------------------------------------------------------------------------
// Usage: the input channel (i_valid / o_stall) takes one item holding an
// action code and its operands; the output channel (o_valid / i_stall)
// returns exactly one residue per item, in order. An item is taken only
// while the sequencer is idle; a finished result sits in the output
// register, so the next item may be taken while the receiver stalls.
// Every multiplication runs through one four-stage multiply and Barrett
// reduction unit, one operation at a time.
// Work per item: negate, add and subtract use no multiplication; multiply uses
// one; reduce uses one per chunk (four 16-bit chunks); pow and inverse square
// once per exponent bit (63) and multiply by the base once per set bit, and
// divide adds one final multiplication. Inverse uses exponent 1000000005
// (15 set bits).
// An item is accepted again once the previous result is loaded into the
// output register. While the receiver stalls, o_valid and the residue hold;
// the sequencer waits with a finished item until that register frees up.
// Synchronous active-low reset returns the sequencer to idle and drops
// o_valid; no arithmetic state survives between items.
// ----------------------------------------------------------------------------
module prime_modular_arithmetic_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [pmau_pkg::ACT_W-1:0]        i_action,
    input  logic signed [pmau_pkg::RAW_W-1:0] i_raw_value,
    input  logic [pmau_pkg::RES_W-1:0]        i_operand_a,
    input  logic [pmau_pkg::RES_W-1:0]        i_operand_b,
    input  logic [pmau_pkg::EXP_W-1:0]        i_exponent,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [pmau_pkg::RES_W-1:0]        o_result_residue
);

    pmau_pkg::t_cmd w_cmd;
    pmau_pkg::t_sts w_sts;

    pmau_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd),
        .i_sts    (w_sts)
    );

    pmau_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_raw_value      (i_raw_value),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .i_exponent       (i_exponent),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_result_residue (o_result_residue)
    );

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> w_sts.out_free)
        else $error("result loaded over an item not yet taken");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result_residue < pmau_pkg::MODULUS))
        else $error("result residue not below the modulus");

    a_mm_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.mm_start |-> !w_sts.mm_busy)
        else $error("multiplier started while an operation is in flight");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("sequencer not busy after taking an item");

endmodule

// File: verif/tb_prime_modular_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_prime_modular_arithmetic_unit: self-checking bench for the mod-prime unit
// A directed table (field extremes, out-of-range operands, zero exponent,
// inverse and divide by zero) is followed by random items. Every result is
// compared in order against a typed value or an in-bench modular predictor,
// with random idling on requests and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_prime_modular_arithmetic_unit;

    localparam int RANDOM_ITEMS   = 380;
    localparam int DIRECTED_ITEMS = 25;
    // covers the slowest item, plus the longest gap and stall
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 700;

    localparam logic [63:0]                MOD64   = 64'(pmau_pkg::MODULUS);
    localparam logic [pmau_pkg::RES_W-1:0] M_MINUS = pmau_pkg::MODULUS - 30'd1;
    localparam logic [pmau_pkg::RES_W-1:0] OP_MAX  = '1;
    localparam logic [pmau_pkg::EXP_W-1:0] EXP_MAX = '1;

    typedef struct packed {
        pmau_pkg::t_action          action;
        logic [pmau_pkg::RAW_W-1:0] raw;
        logic [pmau_pkg::RES_W-1:0] opa;
        logic [pmau_pkg::RES_W-1:0] opb;
        logic [pmau_pkg::EXP_W-1:0] expo;
        logic                       known;
        logic [pmau_pkg::RES_W-1:0] want;
    } t_request;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    logic [pmau_pkg::ACT_W-1:0]        i_action;
    logic signed [pmau_pkg::RAW_W-1:0] i_raw_value;
    logic [pmau_pkg::RES_W-1:0]        i_operand_a;
    logic [pmau_pkg::RES_W-1:0]        i_operand_b;
    logic [pmau_pkg::EXP_W-1:0]        i_exponent;
    logic                              o_valid;
    logic                              i_stall;
    logic [pmau_pkg::RES_W-1:0]        o_result_residue;

    logic [pmau_pkg::RES_W-1:0] expected_residues[$];
    int                         fail_count       = 0;
    int                         items_sent;
    int                         residues_checked = 0;
    int                         action_hits[8];
    int                         idle_cycles      = 0;
    bit                         calm;

    // typed expectations only where they are obvious; the rest use the predictor
    t_request directed_rows[DIRECTED_ITEMS] = '{
        '{pmau_pkg::ACT_REDUCE, 64'd0, '0, '0, '0, 1'b1, 30'd0},
        '{pmau_pkg::ACT_REDUCE, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, '0, 1'b1, M_MINUS},
        '{pmau_pkg::ACT_REDUCE, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0, '0, 1'b0, '0},
        '{pmau_pkg::ACT_REDUCE, 64'h8000_0000_0000_0000, '0, '0, '0, 1'b0, '0},
        '{pmau_pkg::ACT_REDUCE, 64'd1000000007, '0, '0, '0, 1'b1, 30'd0},
        '{pmau_pkg::ACT_REDUCE, -64'd1000000007, '0, '0, '0, 1'b1, 30'd0},
        '{pmau_pkg::ACT_NEGATE, '0, 30'd0, '0, '0, 1'b1, 30'd0},
        '{pmau_pkg::ACT_NEGATE, '0, 30'd1, '0, '0, 1'b1, M_MINUS},
        '{pmau_pkg::ACT_NEGATE, '0, OP_MAX, '0, '0, 1'b0, '0},
        '{pmau_pkg::ACT_NEGATE, '0, pmau_pkg::MODULUS, '0, '0, 1'b1, 30'd0},
        '{pmau_pkg::ACT_ADD, '0, M_MINUS, 30'd1, '0, 1'b1, 30'd0},
        '{pmau_pkg::ACT_ADD, '0, OP_MAX, OP_MAX, '0, 1'b0, '0},
        '{pmau_pkg::ACT_SUB, '0, 30'd0, 30'd1, '0, 1'b1, M_MINUS},
        '{pmau_pkg::ACT_SUB, '0, 30'd5, 30'd5, '0, 1'b1, 30'd0},
        '{pmau_pkg::ACT_MUL, '0, M_MINUS, M_MINUS, '0, 1'b1, 30'd1},
        '{pmau_pkg::ACT_MUL, '0, OP_MAX, OP_MAX, '0, 1'b0, '0},
        '{pmau_pkg::ACT_POW, '0, 30'd0, '0, 63'd0, 1'b1, 30'd1},
        '{pmau_pkg::ACT_POW, '0, OP_MAX, '0, 63'd0, 1'b1, 30'd1},
        '{pmau_pkg::ACT_POW, '0, 30'd2, '0, 63'd10, 1'b1, 30'd1024},
        '{pmau_pkg::ACT_POW, '0, M_MINUS, '0, EXP_MAX, 1'b1, M_MINUS},
        '{pmau_pkg::ACT_POW, '0, 30'd0, '0, 63'd5, 1'b1, 30'd0},
        '{pmau_pkg::ACT_INVERSE, '0, 30'd0, '0, '0, 1'b1, 30'd0},
        '{pmau_pkg::ACT_INVERSE, '0, M_MINUS, '0, '0, 1'b1, M_MINUS},
        '{pmau_pkg::ACT_DIVIDE, '0, 30'd7, 30'd0, '0, 1'b1, 30'd0},
        '{pmau_pkg::ACT_DIVIDE, '0, 30'd6, 30'd3, '0, 1'b1, 30'd2}
    };

    prime_modular_arithmetic_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_action         (i_action),
        .i_raw_value      (i_raw_value),
        .i_operand_a      (i_operand_a),
        .i_operand_b      (i_operand_b),
        .i_exponent       (i_exponent),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_residue (o_result_residue)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] mod_mul(logic [63:0] p, logic [63:0] q);
        return (p * q) % MOD64;
    endfunction

    function automatic logic [63:0] mod_pow(logic [63:0] base,
                                            logic [pmau_pkg::EXP_W-1:0] e);
        logic [63:0] acc;
        acc  = 64'd1;
        base = base % MOD64;
        for (int k = pmau_pkg::EXP_W - 1; k >= 0; k--) begin
            acc = mod_mul(acc, acc);
            if (e[k]) acc = mod_mul(acc, base);
        end
        return acc;
    endfunction

    function automatic logic [63:0] reduce_signed(logic [pmau_pkg::RAW_W-1:0] bits);
        logic [63:0] rem;
        if (bits[pmau_pkg::RAW_W-1]) begin
            rem = (~bits + 64'd1) % MOD64;
            return (rem == 64'd0) ? 64'd0 : MOD64 - rem;
        end
        return bits % MOD64;
    endfunction

    function automatic logic [pmau_pkg::RES_W-1:0] residue_of(t_request req);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] r;
        a = 64'(req.opa) % MOD64;
        b = 64'(req.opb) % MOD64;
        case (req.action)
            pmau_pkg::ACT_REDUCE:  r = reduce_signed(req.raw);
            pmau_pkg::ACT_NEGATE:  r = (a == 64'd0) ? 64'd0 : MOD64 - a;
            pmau_pkg::ACT_ADD:     r = (a + b) % MOD64;
            pmau_pkg::ACT_SUB:     r = (a + MOD64 - b) % MOD64;
            pmau_pkg::ACT_MUL:     r = mod_mul(a, b);
            pmau_pkg::ACT_POW:     r = mod_pow(a, req.expo);
            pmau_pkg::ACT_INVERSE: r = mod_pow(a, pmau_pkg::FERMAT_EXP);
            default:               r = mod_mul(a, mod_pow(b, pmau_pkg::FERMAT_EXP));
        endcase
        return r[pmau_pkg::RES_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 40) return 0;
        if (roll < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [pmau_pkg::RES_W-1:0] pick_operand();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return pmau_pkg::RES_W'($urandom_range(0, pmau_pkg::MODULUS - 1));
        if (roll < 85) return pmau_pkg::RES_W'($urandom);
        case ($urandom_range(0, 4))
            0:       return 30'd0;
            1:       return 30'd1;
            2:       return M_MINUS;
            3:       return pmau_pkg::MODULUS;
            default: return OP_MAX;
        endcase
    endfunction

    // hold the payload until taken; keep valid high when the next item follows at once
    task automatic push_item(input t_request req, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= req.action;
        i_raw_value <= req.raw;
        i_operand_a <= req.opa;
        i_operand_b <= req.opb;
        i_exponent  <= req.expo;
        do @(posedge i_clk); while (o_stall);
        expected_residues.push_back(req.known ? req.want : residue_of(req));
        items_sent++;
        action_hits[req.action]++;
    endtask

    function automatic void note_failure(string msg);
        if (fail_count < 10) $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls
    // ------------------------------------------------------------------
    initial begin : rx_stall
        int hold;
        int run;
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            hold = pick_gap();
            run  = $urandom_range(1, 12);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat (run) @(posedge i_clk);
        end
    end

    // compare each result with the oldest expectation
    always @(posedge i_clk) begin
        logic [pmau_pkg::RES_W-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_residues.size() == 0) begin
                note_failure($sformatf("unexpected residue %0d", o_result_residue));
            end else begin
                want = expected_residues.pop_front();
                residues_checked++;
                if (o_result_residue !== want)
                    note_failure($sformatf("residue expected %0d actual %0d",
                                           want, o_result_residue));
            end
        end
    end

    // end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no item moved for %0d cycles", idle_cycles);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main
        t_request req;
        items_sent = 0;
        calm       = 1'b0;
        foreach (action_hits[k]) action_hits[k] = 0;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_action    <= pmau_pkg::ACT_REDUCE;
        i_raw_value <= '0;
        i_operand_a <= '0;
        i_operand_b <= '0;
        i_exponent  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            req = directed_rows[r];
            // fill fields the action ignores with noise
            if (req.action != pmau_pkg::ACT_REDUCE) req.raw = {$urandom, $urandom};
            else req.opa = pmau_pkg::RES_W'($urandom);
            if (!(req.action inside {pmau_pkg::ACT_ADD, pmau_pkg::ACT_SUB,
                                     pmau_pkg::ACT_MUL, pmau_pkg::ACT_DIVIDE}))
                req.opb = pmau_pkg::RES_W'($urandom);
            if (req.action != pmau_pkg::ACT_POW)
                req.expo = pmau_pkg::EXP_W'({$urandom, $urandom});
            push_item(req, pick_gap());
        end

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            calm       = ((n / 40) % 4 == 2);
            req        = '0;
            req.action = pmau_pkg::t_action'($urandom_range(0, 7));
            req.opa    = pick_operand();
            req.opb    = pick_operand();
            case ($urandom_range(0, 2))
                0: req.raw = {$urandom, $urandom};
                1: req.raw = {{32{1'b0}}, $urandom} - 64'h8000_0000;
                default: begin
                    req.raw = 64'($urandom_range(0, 1000)) * MOD64
                              + 64'($urandom_range(0, 3));
                    if ($urandom_range(0, 1)) req.raw = -req.raw;
                end
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: req.expo = pmau_pkg::EXP_W'({$urandom, $urandom});
                5, 6, 7:       req.expo = pmau_pkg::EXP_W'($urandom_range(0, 100));
                8:             req.expo = EXP_MAX;
                default:       req.expo = ($urandom_range(0, 1))
                                        ? pmau_pkg::FERMAT_EXP
                                        : pmau_pkg::EXP_W'(pmau_pkg::MODULUS);
            endcase
            push_item(req, pick_gap());
        end
        i_valid <= 1'b0;
        calm = 1'b0;

        while (expected_residues.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d items (%0d directed); checked %0d residues, %0d failures",
                 items_sent, DIRECTED_ITEMS, residues_checked, fail_count);
        $display({"Per action: reduce %0d negate %0d add %0d sub %0d",
                  " mul %0d pow %0d inv %0d div %0d"},
                 action_hits[0], action_hits[1], action_hits[2], action_hits[3],
                 action_hits[4], action_hits[5], action_hits[6], action_hits[7]);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
